// ===== sv/scp_pkg.sv =====
package scp_pkg;

  localparam int CFG_DIM_W = 13;
  localparam int CFG_CNT_W = 9;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS   = 4'd3;

  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CFG_CNT_W-1:0] RST_BOARD_COLS   = 9'd8;
  localparam logic [CFG_CNT_W-1:0] RST_BOARD_ROWS   = 9'd6;

  localparam int LANE_DIV_STEPS = CFG_CNT_W;
  localparam int LANE_LAT       = LANE_DIV_STEPS + 2;

endpackage

// ===== sv/scp_derive.sv =====
module scp_derive #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [scp_pkg::CFG_DIM_W-1:0]  image_width,
  input  logic [scp_pkg::CFG_DIM_W-1:0]  image_height,
  input  logic [scp_pkg::CFG_CNT_W-1:0]  board_cols,
  input  logic [scp_pkg::CFG_CNT_W-1:0]  board_rows,
  output logic                           busy,
  output logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] square_size,
  output logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] board_width,
  output logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] board_height,
  output logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] offset_x,
  output logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] offset_y
);
  import scp_pkg::*;

  localparam int DVW = CFG_DIM_W + FRAC_BITS;
  localparam int CNTW = $clog2(DVW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MIN  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_OFS  = 3'd5;

  logic [2:0]           state;
  logic [CNTW-1:0]      cnt;
  logic [DVW-1:0]       wdiv;
  logic [DVW-1:0]       hdiv;
  logic [CFG_CNT_W:0]   remx;
  logic [CFG_CNT_W:0]   remy;
  logic [CFG_CNT_W+1:0] remx_sh;
  logic [CFG_CNT_W+1:0] remy_sh;
  logic [CFG_CNT_W+1:0] divx;
  logic [CFG_CNT_W+1:0] divy;
  logic                 qx;
  logic                 qy;
  logic [DVW-1:0]       wf;
  logic [DVW-1:0]       hf;

  assign busy    = (state != ST_IDLE);
  assign wf      = {image_width, {FRAC_BITS{1'b0}}};
  assign hf      = {image_height, {FRAC_BITS{1'b0}}};
  assign divx    = (CFG_CNT_W+2)'(board_cols) + (CFG_CNT_W+2)'(2);
  assign divy    = (CFG_CNT_W+2)'(board_rows) + (CFG_CNT_W+2)'(2);
  assign remx_sh = {remx, wdiv[DVW-1]};
  assign remy_sh = {remy, hdiv[DVW-1]};
  assign qx      = (remx_sh >= divx);
  assign qy      = (remy_sh >= divy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) state <= ST_LOAD;
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(DVW - 1)) state <= ST_MIN;
        end
        ST_MIN:  state <= ST_MUL;
        ST_MUL:  state <= ST_OFS;
        ST_OFS:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        wdiv <= wf;
        hdiv <= hf;
        remx <= '0;
        remy <= '0;
      end
      ST_DIV: begin
        wdiv <= {wdiv[DVW-2:0], qx};
        hdiv <= {hdiv[DVW-2:0], qy};
        remx <= qx ? (CFG_CNT_W+1)'(remx_sh - divx) : remx_sh[CFG_CNT_W:0];
        remy <= qy ? (CFG_CNT_W+1)'(remy_sh - divy) : remy_sh[CFG_CNT_W:0];
      end
      ST_MIN: begin
        square_size <= (wdiv < hdiv) ? wdiv : hdiv;
      end
      ST_MUL: begin
        board_width  <= DVW'(square_size * DVW'(board_cols));
        board_height <= DVW'(square_size * DVW'(board_rows));
      end
      ST_OFS: begin
        offset_x <= (wf - board_width) >> 1;
        offset_y <= (hf - board_height) >> 1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/scp_lane.sv =====
module scp_lane #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int OFFSET     = 0
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [COORD_BITS-1:0]                   coord,
  input  logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] origin,
  input  logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] extent,
  input  logic [scp_pkg::CFG_DIM_W+FRAC_BITS-1:0] square_size,
  output logic                                    in_board,
  output logic                                    odd
);
  import scp_pkg::*;

  localparam int RW  = CFG_DIM_W + FRAC_BITS;
  localparam int LXW = ((COORD_BITS > CFG_DIM_W) ? COORD_BITS : CFG_DIM_W) + FRAC_BITS + 2;
  localparam int DW  = RW + LANE_DIV_STEPS;
  localparam int NST = LANE_DIV_STEPS - 1;

  logic signed [LXW-1:0] lx_next;
  logic signed [LXW-1:0] lx;
  logic [RW-1:0]         rem [0:NST];
  logic                  ins [0:NST];

  assign lx_next = $signed(LXW'({coord, {FRAC_BITS{1'b0}}})) + LXW'(OFFSET)
                 - $signed(LXW'(origin));

  always_ff @(posedge clk) begin
    if (en) begin
      lx     <= lx_next;
      ins[0] <= !lx[LXW-1] && (lx < $signed(LXW'(extent)));
      rem[0] <= lx[RW-1:0];
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_step
    logic [DW-1:0] dsh;
    logic [DW-1:0] rwide;
    assign dsh   = DW'(square_size) << (NST - k);
    assign rwide = DW'(rem[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        ins[k+1] <= ins[k];
        rem[k+1] <= (rwide >= dsh) ? RW'(rwide - dsh) : rem[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_board <= ins[NST];
      odd      <= (rem[NST] >= square_size);
    end
  end

endmodule

// ===== sv/supersampled_checkerboard_pixel.sv =====
// Anti-aliased checkerboard test pattern, one pixel per item.
//
// Input stream: s_tdata carries a pixel column and row; the block returns
// one 8-bit grey value on the output stream for every item, in order.
// Configuration: write image_width (0), image_height (1), board_cols (2) or
// board_rows (3) on the cfg channel while the block is idle. Each write to
// one of these registers starts a geometry recompute (one quotient bit per
// cycle in two parallel restoring dividers, one per axis); cfg_ready and
// s_tready stay low meanwhile. Writes to other indexes are dropped.
// Reset restores 640 x 480 with an 8 x 6 board and runs the same recompute
// before the first item is taken.
// Throughput: one item per cycle while the receiver is ready and no recompute
// runs. Each item passes through the nine-step per-sub-sample pipelined divider.
// When the receiver stalls, the whole pipeline holds; one more item is caught
// in an input skid register, after which s_tready drops.
module supersampled_checkerboard_pixel #(
  parameter int COORD_BITS          = 12,
  parameter int FRAC_BITS           = 16,
  parameter int SUBSAMPLES_PER_AXIS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // pixel_x, pixel_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // grey_value
  output logic [7:0]                             m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [scp_pkg::CFG_DIM_W-1:0]          cfg_data
);
  import scp_pkg::*;

  localparam int SS  = SUBSAMPLES_PER_AXIS;
  localparam int N   = SS * SS;
  localparam int CW  = $clog2(N + 1);
  localparam int RW  = CFG_DIM_W + FRAC_BITS;
  localparam int VLN = LANE_LAT + 2;

  logic [CFG_DIM_W-1:0]  image_width;
  logic [CFG_DIM_W-1:0]  image_height;
  logic [CFG_CNT_W-1:0]  board_cols;
  logic [CFG_CNT_W-1:0]  board_rows;
  logic                  cfg_write;
  logic                  busy;
  logic [RW-1:0]         square_size;
  logic [RW-1:0]         board_width;
  logic [RW-1:0]         board_height;
  logic [RW-1:0]         offset_x;
  logic [RW-1:0]         offset_y;

  logic                  en;
  logic                  in_acc;
  logic                  skid_valid;
  logic [COORD_BITS-1:0] skid_x;
  logic [COORD_BITS-1:0] skid_y;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic                  vp [0:VLN-1];

  logic [SS-1:0]         in_x;
  logic [SS-1:0]         in_y;
  logic [SS-1:0]         odd_x;
  logic [SS-1:0]         odd_y;
  logic [N-1:0]          white;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         count;
  logic [7:0]            grey_lut [0:N];

  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_ready = !busy;
  assign s_tready  = !skid_valid && !busy;
  assign in_acc    = s_tvalid && s_tready;
  assign en        = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      board_cols   <= RST_BOARD_COLS;
      board_rows   <= RST_BOARD_ROWS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_BOARD_COLS:   board_cols   <= cfg_data[CFG_CNT_W-1:0];
        REG_BOARD_ROWS:   board_rows   <= cfg_data[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  scp_derive #(.FRAC_BITS(FRAC_BITS)) u_derive (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_write && (cfg_index <= REG_BOARD_ROWS)),
    .image_width  (image_width),
    .image_height (image_height),
    .board_cols   (board_cols),
    .board_rows   (board_rows),
    .busy         (busy),
    .square_size  (square_size),
    .board_width  (board_width),
    .board_height (board_height),
    .offset_x     (offset_x),
    .offset_y     (offset_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !en) begin
      skid_x <= s_tdata[COORD_BITS-1:0];
      skid_y <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
    if (en) begin
      px <= skid_valid ? skid_x : s_tdata[COORD_BITS-1:0];
      py <= skid_valid ? skid_y : s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VLN; i++) vp[i] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vp[0] <= skid_valid || in_acc;
      for (int i = 1; i < VLN; i++) vp[i] <= vp[i-1];
      m_tvalid <= vp[VLN-1];
    end
  end

  for (genvar s = 0; s < SS; s++) begin : g_lane
    localparam int OFF = ((2*s + 1 - SS) * (1 << FRAC_BITS)) / (2*SS);
    scp_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .OFFSET(OFF)) u_x (
      .clk(clk), .en(en), .coord(px), .origin(offset_x), .extent(board_width),
      .square_size(square_size), .in_board(in_x[s]), .odd(odd_x[s])
    );
    scp_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .OFFSET(OFF)) u_y (
      .clk(clk), .en(en), .coord(py), .origin(offset_y), .extent(board_height),
      .square_size(square_size), .in_board(in_y[s]), .odd(odd_y[s])
    );
  end

  for (genvar j = 0; j < SS; j++) begin : g_row
    for (genvar i = 0; i < SS; i++) begin : g_col
      assign white[j*SS+i] = !in_x[i] || !in_y[j] || (odd_x[i] == odd_y[j]);
    end
  end

  for (genvar g = 0; g <= N; g++) begin : g_lut
    localparam int GV = (510*g + N) / (2*N);
    assign grey_lut[g] = 8'(GV);
  end

  always_comb begin
    count_next = '0;
    for (int i = 0; i < N; i++) count_next = count_next + CW'(white[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count   <= count_next;
      m_tdata <= grey_lut[count];
    end
  end

endmodule

// ===== sv/scp_checker.sv =====
module scp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [7:0]                    m_tdata,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [scp_pkg::CFG_IDX_W-1:0] cfg_index
);
  import scp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !cfg_ready && !s_tready)
    else $error("outputs active after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled item changed");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index <= REG_BOARD_ROWS) |=> !cfg_ready && !s_tready)
    else $error("recompute did not block the channels");

  a_no_item_during_cfg: assert property (@(posedge clk) disable iff (rst)
    !cfg_ready |-> !s_tready)
    else $error("item taken during recompute");

endmodule

bind supersampled_checkerboard_pixel scp_checker u_scp_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);
